FILE: sv/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg: shared types and constants for the PCG32 generator
// Opcodes, register indexes, sequencer states and the LCG constants.
// ----------------------------------------------------------------------------
package pcg_pkg;

    localparam logic [63:0] LCG_MULT            = 64'd6364136223846793005;
    localparam logic [63:0] RESET_SEED_STATE    = 64'h853c49e6748fea9b;
    localparam logic [63:0] RESET_SEED_SEQUENCE = 64'hda3e39cb94b95bdb;

    localparam int DIGIT_W = 4;

    localparam logic [2:0] OP_RESEED = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_RANGE  = 3'd2;
    localparam logic [2:0] OP_FAST   = 3'd3;
    localparam logic [2:0] OP_BOOL   = 3'd4;

    localparam logic CFG_SEED_STATE    = 1'b0;
    localparam logic CFG_SEED_SEQUENCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SEED_D1,
        ST_SEED_D2,
        ST_DRAW,
        ST_DIVT,
        ST_DIVR,
        ST_OUT
    } t_state;

endpackage

FILE: sv/pcg_step.sv
// ----------------------------------------------------------------------------
// pcg_step: digit-serial LCG advance and XSH-RR output permutation
// Multiplies the state by the LCG constant four bits per cycle and adds the
// increment; the permuted draw comes from the latched old state.
// ----------------------------------------------------------------------------
module pcg_step
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_state,
    input  logic [63:0] i_inc,
    output logic        o_done,
    output logic [63:0] o_next,
    output logic [31:0] o_draw
);

    localparam int STEPS = 64 / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [63:0]      r_acc;
    logic [63:0]      r_mcand;
    logic [63:0]      r_old;

    logic [DIGIT_W-1:0] w_digit;
    logic [63:0]        w_prod;
    logic [31:0]        w_mixed;
    logic [63:0]        w_rot;

    assign w_digit = LCG_MULT[r_cnt * DIGIT_W +: DIGIT_W];
    assign w_prod  = r_mcand * {{(64 - DIGIT_W){1'b0}}, w_digit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= i_inc;
            r_mcand <= i_state;
            r_old   <= i_state;
        end else if (r_busy) begin
            r_acc   <= r_acc + w_prod;
            r_mcand <= r_mcand << DIGIT_W;
        end
    end

    assign w_mixed = 32'(((r_old >> 18) ^ r_old) >> 27);
    assign w_rot   = {w_mixed, w_mixed} >> r_old[63:59];

    assign o_done = r_done;
    assign o_next = r_acc;
    assign o_draw = w_rot[31:0];

endmodule

FILE: sv/pcg_div.sv
// ----------------------------------------------------------------------------
// pcg_div: bit-serial restoring remainder unit
// Shifts one dividend bit per cycle into a partial remainder.
// ----------------------------------------------------------------------------
module pcg_div
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;

    logic [32:0] w_trial;
    logic [32:0] w_sub;

    assign w_trial = {r_rem, r_num[31]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_sub[32]) begin
                r_rem <= w_sub[31:0];
            end else begin
                r_rem <= w_trial[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/pcg32_random_with_ranges.sv
// ----------------------------------------------------------------------------
// pcg32_random_with_ranges: PCG32 XSH-RR generator with range draws
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_tvalid / o_s_tready    op, range_min, range_max
//  m_axis    out  o_m_tvalid / i_m_tready    value
//  cfg       in   i_cfg_we                   seed_state, seed_sequence
//
// A draw runs in the four-bit serial LCG multiplier, a remainder in the
// bit-serial divider. Raw takes one draw; fast range a draw and a remainder;
// unbiased range a threshold remainder, draws until one passes, a remainder;
// reseed two LCG steps. After reset it reseeds with the reset seeds before
// it accepts a beat. A stalled result holds in the output register; the next
// beat is accepted meanwhile and its result waits until that register frees.
// ----------------------------------------------------------------------------
module pcg32_random_with_ranges
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // op[2:0], range_min[34:3], range_max[66:35], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // value[31:0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [63:0] r_seed_state;
    logic [63:0] r_seed_seq;
    logic [63:0] r_lcg;
    logic [63:0] r_inc;
    logic        r_boot;
    logic [2:0]  r_op;
    logic [31:0] r_lo;
    logic [31:0] r_bound;
    logic [31:0] r_thr;
    logic [31:0] r_res;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [2:0]  w_op;
    logic [31:0] w_min;
    logic [31:0] w_max;
    logic [31:0] w_bound;
    logic [31:0] w_lo;
    logic        w_accept;
    logic        w_out_free;
    logic [63:0] w_seed_inc;

    logic        w_draw_start;
    logic [63:0] w_draw_state;
    logic [63:0] w_draw_inc;
    logic        w_div_start;
    logic [31:0] w_div_num;
    logic [31:0] w_div_den;
    logic        w_res_load;
    logic [31:0] w_res_val;
    logic        w_lcg_load;

    logic        w_step_done;
    logic [63:0] w_step_next;
    logic [31:0] w_step_draw;
    logic        w_div_done;
    logic [31:0] w_div_rem;

    assign w_op    = i_s_tdata[2:0];
    assign w_min   = i_s_tdata[34:3];
    assign w_max   = i_s_tdata[66:35];
    assign w_bound = (w_op == OP_BOOL) ? 32'd2 : (w_max - w_min);
    assign w_lo    = (w_op == OP_BOOL) ? 32'd0 : w_min;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_seed_inc = {r_seed_seq[62:0], 1'b1};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_RESEED: n_state = ST_SEED;
                        OP_RAW:    n_state = ST_DRAW;
                        OP_RANGE:  n_state = (w_min == w_max) ? ST_OUT : ST_DIVT;
                        OP_FAST:   n_state = (w_min == w_max) ? ST_OUT : ST_DRAW;
                        OP_BOOL:   n_state = ST_DIVT;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end
            ST_SEED:    n_state = ST_SEED_D1;
            ST_SEED_D1: if (w_step_done) n_state = ST_SEED_D2;
            ST_SEED_D2: if (w_step_done) n_state = r_boot ? ST_IDLE : ST_OUT;
            ST_DRAW: begin
                if (w_step_done) begin
                    if (r_op == OP_RAW) begin
                        n_state = ST_OUT;
                    end else if (r_op == OP_FAST || w_step_draw >= r_thr) begin
                        n_state = ST_DIVR;
                    end
                end
            end
            ST_DIVT: if (w_div_done) n_state = ST_DRAW;
            ST_DIVR: if (w_div_done) n_state = ST_OUT;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_draw_start = 1'b0;
        w_draw_state = r_lcg;
        w_draw_inc   = r_inc;
        w_div_start  = 1'b0;
        w_div_num    = w_step_draw;
        w_div_den    = r_bound;
        w_res_load   = 1'b0;
        w_res_val    = 32'd0;
        w_lcg_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_RESEED: ;
                        OP_RAW: w_draw_start = 1'b1;
                        OP_RANGE, OP_BOOL: begin
                            if (w_op == OP_RANGE && w_min == w_max) begin
                                w_res_load = 1'b1;
                                w_res_val  = w_min;
                            end else begin
                                w_div_start = 1'b1;
                                w_div_num   = 32'd0 - w_bound;
                                w_div_den   = w_bound;
                            end
                        end
                        OP_FAST: begin
                            if (w_min == w_max) begin
                                w_res_load = 1'b1;
                                w_res_val  = w_min;
                            end else begin
                                w_draw_start = 1'b1;
                            end
                        end
                        default: w_res_load = 1'b1;
                    endcase
                end
            end
            ST_SEED: begin
                w_draw_start = 1'b1;
                w_draw_state = 64'd0;
                w_draw_inc   = w_seed_inc;
            end
            ST_SEED_D1: begin
                if (w_step_done) begin
                    w_draw_start = 1'b1;
                    w_draw_state = w_step_next + r_seed_state;
                end
            end
            ST_SEED_D2: begin
                if (w_step_done) begin
                    w_lcg_load = 1'b1;
                    w_res_load = 1'b1;
                end
            end
            ST_DRAW: begin
                if (w_step_done) begin
                    w_lcg_load = 1'b1;
                    if (r_op == OP_RAW) begin
                        w_res_load = 1'b1;
                        w_res_val  = w_step_draw;
                    end else if (r_op == OP_FAST || w_step_draw >= r_thr) begin
                        w_div_start = 1'b1;
                    end else begin
                        w_draw_start = 1'b1;
                        w_draw_state = w_step_next;
                    end
                end
            end
            ST_DIVT: if (w_div_done) w_draw_start = 1'b1;
            ST_DIVR: begin
                if (w_div_done) begin
                    w_res_load = 1'b1;
                    w_res_val  = r_lo + w_div_rem;
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SEED;
            r_boot       <= 1'b1;
            r_out_valid  <= 1'b0;
            r_seed_state <= RESET_SEED_STATE;
            r_seed_seq   <= RESET_SEED_SEQUENCE;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEED_D2 && w_step_done) begin
                r_boot <= 1'b0;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEED_STATE:    r_seed_state <= i_cfg_data;
                    CFG_SEED_SEQUENCE: r_seed_seq   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEED) begin
            r_inc <= w_seed_inc;
        end
        if (w_lcg_load) begin
            r_lcg <= w_step_next;
        end
        if (w_accept) begin
            r_op    <= w_op;
            r_lo    <= w_lo;
            r_bound <= w_bound;
        end
        if (r_state == ST_DIVT && w_div_done) begin
            r_thr <= w_div_rem;
        end
        if (r_state == ST_IDLE && w_accept && w_op == OP_FAST) begin
            r_thr <= 32'd0;
        end
        if (w_res_load) begin
            r_res <= w_res_val;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data <= r_res;
        end
    end

    pcg_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_draw_start),
        .i_state (w_draw_state),
        .i_inc   (w_draw_inc),
        .o_done  (w_step_done),
        .o_next  (w_step_next),
        .o_draw  (w_step_draw)
    );

    pcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
